// ===== design/tccw_pkg.sv =====
package tccw_pkg;

    localparam int unsigned OPCODE_W    = 2;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned COLOR_W     = 4;
    localparam int unsigned READ_ROW_W  = 5;
    localparam int unsigned READ_COL_W  = 7;
    localparam int unsigned LOCATION_W  = 11;
    localparam int unsigned CELL_W      = 16;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned M_TDATA_W   = 32;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7F;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUT   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_EXEC   = 7'b0000100,
        ST_SCROLL = 7'b0001000,
        ST_RADDR  = 7'b0010000,
        ST_RWAIT  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

endpackage

// ===== design/text_console_char_writer.sv =====
// Text console character engine: a ROWS x COLUMNS store of 16-bit cells
// (attribute high byte, character low byte) with a cursor.
// Input channel s_axis_*: one transaction per command (put character,
// clear screen, read one cell). Result channel m_axis_*: one transaction
// per command, carrying the cursor location and the cell read (zero for
// anything but a read).
// Each command passes from the idle state through the execute and done
// states to the output register; a read adds an address state and a
// memory-wait state, a put that scrolls adds a sweep that blanks one row,
// and a clear sweeps every cell. Commands are taken only in the idle
// state, so a new one is accepted only once the last has left the done
// state; each sweep writes one cell of the cell memory per cycle.
// Scrolling rotates a top-row pointer and blanks one row, so no cells move.
// After reset the block sweeps all ROWS * COLUMNS cells to blank, one per
// cycle, with s_axis_tready low and the cursor at home.
// A result waits in the output register while m_axis_tready is low; the
// next command is still taken, and its result waits until the slot frees.
module text_console_char_writer #(
    parameter int unsigned COLUMNS  = 80,
    parameter int unsigned ROWS     = 25,
    parameter int unsigned TAB_STOP = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // opcode[1:0], char_code[9:2], bg_colour[13:10], fg_colour[17:14],
    // read_row[22:18], read_column[29:23], zero pad
    input  logic [tccw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // cursor_location[10:0], cell_value[26:11], zero pad
    output logic [tccw_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int unsigned CELLS     = ROWS * COLUMNS;
    localparam int unsigned AW        = $clog2(CELLS);
    localparam int unsigned CW        = $clog2(COLUMNS);
    localparam int unsigned CTW       = $clog2(COLUMNS + TAB_STOP);
    localparam int unsigned RW        = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int unsigned PW        = $clog2(TAB_STOP);
    localparam int unsigned RSW       = ((RW > tccw_pkg::READ_ROW_W) ? RW
                                         : tccw_pkg::READ_ROW_W) + 1;
    localparam int unsigned LW        = AW + tccw_pkg::LOCATION_W;
    localparam int unsigned PAD_W     = tccw_pkg::M_TDATA_W - tccw_pkg::LOCATION_W
                                        - tccw_pkg::CELL_W;
    localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);

    tccw_pkg::state_t state_reg, state_next;

    logic [CW-1:0]  col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [PW-1:0]  phase_reg, phase_next;
    logic [RW-1:0]  top_reg, top_next;
    logic [AW-1:0]  top_base_reg, top_base_next;
    logic [AW-1:0]  cur_base_reg, cur_base_next;
    logic [AW-1:0]  swp_addr_reg, swp_addr_next;
    logic [CW-1:0]  swp_col_reg, swp_col_next;
    logic           clr_op_reg, clr_op_next;
    logic           m_valid_reg, m_valid_next;

    tccw_pkg::opcode_t                  op_reg;
    logic [tccw_pkg::CHAR_W-1:0]        ch_reg;
    logic [2*tccw_pkg::COLOR_W-1:0]     attr_reg;
    logic [tccw_pkg::READ_ROW_W-1:0]    rrow_reg;
    logic [tccw_pkg::READ_COL_W-1:0]    rcol_reg;
    logic [RW-1:0]                      prow_reg, prow_next;
    logic [tccw_pkg::CELL_W-1:0]        cell_reg, cell_next;
    logic [tccw_pkg::M_TDATA_W-1:0]     m_data_reg, m_data_next;

    logic [tccw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tccw_pkg::CELL_W-1:0] mem_rd_q;
    logic                        mem_we;
    logic [AW-1:0]               mem_wa;
    logic [tccw_pkg::CELL_W-1:0] mem_wd;
    logic                        mem_re;
    logic [AW-1:0]               mem_ra;

    logic                        s_accept;
    logic [CTW-1:0]              col_t;
    logic                        row_adv;
    logic [RSW-1:0]              rsum;
    logic [LW-1:0]               loc_wide;

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == tccw_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign loc_wide = LW'(row_reg) * LW'(COLUMNS) + LW'(col_reg);
    assign rsum     = RSW'(rrow_reg) + RSW'(top_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_rd_q <= mem[mem_ra];
        end
    end

    always_comb begin
        state_next    = state_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        phase_next    = phase_reg;
        top_next      = top_reg;
        top_base_next = top_base_reg;
        cur_base_next = cur_base_reg;
        swp_addr_next = swp_addr_reg;
        swp_col_next  = swp_col_reg;
        clr_op_next   = clr_op_reg;
        prow_next     = prow_reg;
        cell_next     = cell_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        mem_we        = 1'b0;
        mem_wa        = swp_addr_reg;
        mem_wd        = tccw_pkg::BLANK_CELL;
        mem_re        = 1'b0;
        mem_ra        = AW'(prow_reg) * AW'(COLUMNS) + AW'(rcol_reg);
        col_t         = CTW'(col_reg);
        row_adv       = 1'b0;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tccw_pkg::ST_CLEAR: begin
                mem_we        = 1'b1;
                swp_addr_next = swp_addr_reg + AW'(1);
                if (swp_addr_reg == AW'(CELLS - 1)) begin
                    state_next = clr_op_reg ? tccw_pkg::ST_DONE : tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (s_accept) begin
                    cell_next  = '0;
                    state_next = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_EXEC: begin
                state_next = tccw_pkg::ST_DONE;
                case (op_reg)
                    tccw_pkg::OP_PUT: begin
                        if (ch_reg == tccw_pkg::CH_BACKSPACE) begin
                            if (col_reg != '0) begin
                                col_t      = CTW'(col_reg) - CTW'(1);
                                phase_next = (phase_reg == '0) ? PW'(TAB_STOP - 1)
                                                               : phase_reg - PW'(1);
                            end
                        end else if (ch_reg == tccw_pkg::CH_TAB) begin
                            col_t      = CTW'(col_reg) + CTW'(TAB_STOP) - CTW'(phase_reg);
                            phase_next = '0;
                        end else if (ch_reg == tccw_pkg::CH_CR) begin
                            col_t      = '0;
                            phase_next = '0;
                        end else if (ch_reg == tccw_pkg::CH_LF) begin
                            col_t      = '0;
                            phase_next = '0;
                            row_adv    = 1'b1;
                        end else if (ch_reg inside {[tccw_pkg::CH_PRINT_LO :
                                                     tccw_pkg::CH_PRINT_HI]}) begin
                            mem_we     = 1'b1;
                            mem_wa     = cur_base_reg + AW'(col_reg);
                            mem_wd     = {attr_reg, ch_reg};
                            col_t      = CTW'(col_reg) + CTW'(1);
                            phase_next = (phase_reg == PW'(TAB_STOP - 1)) ? '0
                                                                          : phase_reg + PW'(1);
                        end
                        if (col_t >= CTW'(COLUMNS)) begin
                            col_t      = '0;
                            phase_next = '0;
                            row_adv    = 1'b1;
                        end
                        col_next = CW'(col_t);
                        if (row_adv) begin
                            if (row_reg == RW'(ROWS - 1)) begin
                                cur_base_next = top_base_reg;
                                swp_addr_next = top_base_reg;
                                swp_col_next  = '0;
                                if (top_reg == RW'(ROWS - 1)) begin
                                    top_next      = '0;
                                    top_base_next = '0;
                                end else begin
                                    top_next      = top_reg + RW'(1);
                                    top_base_next = top_base_reg + AW'(COLUMNS);
                                end
                                state_next = tccw_pkg::ST_SCROLL;
                            end else begin
                                row_next      = row_reg + RW'(1);
                                cur_base_next = (cur_base_reg == LAST_BASE) ? '0
                                                : cur_base_reg + AW'(COLUMNS);
                            end
                        end
                    end
                    tccw_pkg::OP_CLEAR: begin
                        col_next      = '0;
                        row_next      = '0;
                        phase_next    = '0;
                        top_next      = '0;
                        top_base_next = '0;
                        cur_base_next = '0;
                        swp_addr_next = '0;
                        clr_op_next   = 1'b1;
                        state_next    = tccw_pkg::ST_CLEAR;
                    end
                    tccw_pkg::OP_READ: begin
                        if ((32'(rrow_reg) < ROWS) && (32'(rcol_reg) < COLUMNS)) begin
                            prow_next  = (rsum >= RSW'(ROWS)) ? RW'(rsum - RSW'(ROWS))
                                                              : RW'(rsum);
                            state_next = tccw_pkg::ST_RADDR;
                        end
                    end
                    default: begin
                        state_next = tccw_pkg::ST_DONE;
                    end
                endcase
            end
            tccw_pkg::ST_SCROLL: begin
                mem_we        = 1'b1;
                swp_addr_next = swp_addr_reg + AW'(1);
                swp_col_next  = swp_col_reg + CW'(1);
                if (swp_col_reg == CW'(COLUMNS - 1)) begin
                    state_next = tccw_pkg::ST_DONE;
                end
            end
            tccw_pkg::ST_RADDR: begin
                mem_re     = 1'b1;
                state_next = tccw_pkg::ST_RWAIT;
            end
            tccw_pkg::ST_RWAIT: begin
                cell_next  = mem_rd_q;
                state_next = tccw_pkg::ST_DONE;
            end
            tccw_pkg::ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_data_next  = {{PAD_W{1'b0}}, cell_reg,
                                    loc_wide[tccw_pkg::LOCATION_W-1:0]};
                    m_valid_next = 1'b1;
                    clr_op_next  = 1'b0;
                    state_next   = tccw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tccw_pkg::ST_CLEAR;
            col_reg      <= '0;
            row_reg      <= '0;
            phase_reg    <= '0;
            top_reg      <= '0;
            top_base_reg <= '0;
            cur_base_reg <= '0;
            swp_addr_reg <= '0;
            swp_col_reg  <= '0;
            clr_op_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            phase_reg    <= phase_next;
            top_reg      <= top_next;
            top_base_reg <= top_base_next;
            cur_base_reg <= cur_base_next;
            swp_addr_reg <= swp_addr_next;
            swp_col_reg  <= swp_col_next;
            clr_op_reg   <= clr_op_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= tccw_pkg::opcode_t'(s_axis_tdata[1:0]);
            ch_reg   <= s_axis_tdata[9:2];
            attr_reg <= {s_axis_tdata[13:10], s_axis_tdata[17:14]};
            rrow_reg <= s_axis_tdata[22:18];
            rcol_reg <= s_axis_tdata[29:23];
        end
        prow_reg   <= prow_next;
        cell_reg   <= cell_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== sim/text_console_char_writer_test.sv =====
`timescale 1ns / 100ps

module text_console_char_writer_test;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int TAB_STOP     = 8;
    localparam int CELLS        = COLUMNS * ROWS;
    localparam int RANDOM_ITEMS = 450;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [tccw_pkg::LOCATION_W-1:0] location;
        logic [tccw_pkg::CELL_W-1:0]     cell_val;
    } console_result_t;

    logic                           aclk    = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [tccw_pkg::S_TDATA_W-1:0] s_data  = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [tccw_pkg::M_TDATA_W-1:0] m_data;

    logic [tccw_pkg::S_TDATA_W-1:0] pending_cmds[$];
    console_result_t                awaited_results[$];
    logic [tccw_pkg::CELL_W-1:0]    screen_cells [0:CELLS-1];
    int                             cursor_col  = 0;
    int                             cursor_row  = 0;
    int                             gap_left    = 0;
    int                             stall_left  = 0;
    int                             idle_cycles = 0;
    int                             error_count = 0;
    bit                             in_taken    = 1'b0;
    logic [31:0]                    cycle_count = '0;

    text_console_char_writer #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [tccw_pkg::S_TDATA_W-1:0] pack_cmd(
        tccw_pkg::opcode_t op, logic [7:0] ch, logic [3:0] back, logic [3:0] fore,
        logic [4:0] row, logic [6:0] col);
        return {2'b00, col, row, fore, back, ch, op};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return $urandom_range(1, 2);
        end else if (r < 92) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic bit calm_phase();
        return cycle_count[10:9] == 2'b11;
    endfunction

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++) begin
            screen_cells[i] = tccw_pkg::BLANK_CELL;
        end
    endfunction

    function automatic console_result_t console_step(logic [tccw_pkg::S_TDATA_W-1:0] cmd);
        logic [1:0]      op;
        logic [7:0]      ch;
        logic [3:0]      back;
        logic [3:0]      fore;
        logic [4:0]      row;
        logic [6:0]      col;
        int              loc;
        console_result_t res;
        op   = cmd[1:0];
        ch   = cmd[9:2];
        back = cmd[13:10];
        fore = cmd[17:14];
        row  = cmd[22:18];
        col  = cmd[29:23];
        res.cell_val = '0;
        case (tccw_pkg::opcode_t'(op))
            tccw_pkg::OP_PUT: begin
                if (ch == tccw_pkg::CH_BACKSPACE) begin
                    if (cursor_col != 0) cursor_col--;
                end else if (ch == tccw_pkg::CH_TAB) begin
                    cursor_col = (cursor_col / TAB_STOP + 1) * TAB_STOP;
                end else if (ch == tccw_pkg::CH_CR) begin
                    cursor_col = 0;
                end else if (ch == tccw_pkg::CH_LF) begin
                    cursor_col = 0;
                    cursor_row++;
                end else if (ch >= tccw_pkg::CH_PRINT_LO && ch <= tccw_pkg::CH_PRINT_HI) begin
                    screen_cells[cursor_row * COLUMNS + cursor_col] = {back, fore, ch};
                    cursor_col++;
                end
                if (cursor_col >= COLUMNS) begin
                    cursor_col = 0;
                    cursor_row++;
                end
                if (cursor_row >= ROWS) begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) begin
                        screen_cells[i] = screen_cells[i + COLUMNS];
                    end
                    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) begin
                        screen_cells[i] = tccw_pkg::BLANK_CELL;
                    end
                    cursor_row = ROWS - 1;
                end
            end
            tccw_pkg::OP_CLEAR: begin
                blank_screen();
                cursor_col = 0;
                cursor_row = 0;
            end
            tccw_pkg::OP_READ: begin
                if (row < ROWS && col < COLUMNS) begin
                    res.cell_val = screen_cells[row * COLUMNS + col];
                end
            end
            default: begin
            end
        endcase
        loc = cursor_row * COLUMNS + cursor_col;
        res.location = loc[tccw_pkg::LOCATION_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
        error_count++;
    endtask

    always @(negedge aclk) begin : cmd_driver
        logic next_valid;
        next_valid = s_valid;
        if (aresetn && (!s_valid || in_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_cmds.size() != 0) begin
                s_data <= pending_cmds.pop_front();
                next_valid = 1'b1;
                gap_left = (calm_phase() || $urandom_range(0, 99) < 40) ? 0 : pick_gap();
            end
        end
        s_valid <= next_valid;
    end

    always @(negedge aclk) begin : result_sink
        logic next_ready;
        next_ready = 1'b1;
        if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
        end else if (!calm_phase() && $urandom_range(0, 99) < 25) begin
            stall_left = pick_gap();
        end
        m_ready <= next_ready;
    end

    always @(posedge aclk) begin : result_check
        console_result_t want;
        cycle_count <= cycle_count + 32'd1;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            awaited_results.push_back(console_step(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with none outstanding", '0, m_data);
            end else begin
                want = awaited_results.pop_front();
                if (m_data[10:0] !== want.location) begin
                    report_mismatch("cursor_location", 32'(want.location),
                                    32'(m_data[10:0]));
                end
                if (m_data[26:11] !== want.cell_val) begin
                    report_mismatch("cell_value", 32'(want.cell_val), 32'(m_data[26:11]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        int                r;
        tccw_pkg::opcode_t op;
        logic [7:0]        ch;
        logic [3:0]        back;
        logic [3:0]        fore;
        logic [4:0]        row;
        logic [6:0]        col;

        blank_screen();

        // reads at two corners, just outside the screen and at the largest row and column
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd24, 7'd79));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd25, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd80));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE,
                                        4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_PRINT_LO,
                                        4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_PRINT_HI,
                                        4'hF, 4'hF, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, 8'h41, 4'hF, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_BACKSPACE,
                                        4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_TAB,
                                        4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_CR,
                                        4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd1));
        // bytes that must change nothing
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, 8'h00, 4'h3, 4'h5, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, 8'h1F, 4'h3, 4'h5, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, 8'h80, 4'h3, 4'h5, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, 8'hFF, 4'h3, 4'h5, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, tccw_pkg::CH_LF,
                                        4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_NOP, 8'hFF, 4'hF, 4'hF, 5'h1F, 7'h7F));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_PUT, 8'h5A, 4'hA, 4'h5, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd1, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_CLEAR, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        pending_cmds.push_back(pack_cmd(tccw_pkg::OP_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd1));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            r    = $urandom_range(0, 999);
            ch   = 8'($urandom_range(0, 255));
            back = 4'($urandom_range(0, 15));
            fore = 4'($urandom_range(0, 15));
            row  = 5'($urandom_range(0, 31));
            col  = 7'($urandom_range(0, 127));
            op   = tccw_pkg::OP_PUT;
            if (r < 4) begin
                op = tccw_pkg::OP_CLEAR;
            end else if (r < 20) begin
                op = tccw_pkg::OP_NOP;
            end else if (r < 170) begin
                op = tccw_pkg::OP_READ;
                if (r < 155) begin
                    row = 5'($urandom_range(0, ROWS - 1));
                    col = 7'($urandom_range(0, COLUMNS - 1));
                end
            end else if (r < 190) begin
                op = tccw_pkg::OP_PUT;
            end else if (r < 340) begin
                ch = tccw_pkg::CH_LF;
            end else if (r < 390) begin
                ch = tccw_pkg::CH_TAB;
            end else if (r < 420) begin
                ch = tccw_pkg::CH_BACKSPACE;
            end else if (r < 445) begin
                ch = tccw_pkg::CH_CR;
            end else begin
                ch = 8'($urandom_range(tccw_pkg::CH_PRINT_LO, tccw_pkg::CH_PRINT_HI));
            end
            pending_cmds.push_back(pack_cmd(op, ch, back, fore, row, col));
        end

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_valid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
